// ===== hdl/amwf_pkg.sv =====
// shared types, constants and the fade curve table for the audio mixer
// no dependencies; every other file in hdl/ imports this package
package amwf_pkg;

    // field widths
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int RUN_W       = 20;
    localparam int PHASE_W     = 21;
    localparam int FRAC_W      = 20;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // default for the top level parameter
    localparam int POSITION_BITS_DEF = 20;

    // curve table geometry
    localparam int CURVE_POINTS  = 64;
    localparam int CURVE_SPAN    = CURVE_POINTS - 1;
    localparam int CURVE_ENTRIES = 3 * CURVE_POINTS;
    localparam int CURVE_IDX_W   = $clog2(CURVE_POINTS);
    localparam int CURVE_ADDR_W  = $clog2(CURVE_ENTRIES);

    // front to back queue depth
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PHASE_W-1:0] UNITY_Q20 = 21'h100000;
    localparam logic [16:0]        UNITY_Q15 = 17'd32768;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_MASTER_GAIN    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_GAIN      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_GAIN     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO_MODE    = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_KIND      = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_LENGTH     = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_LENGTH    = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_INCREMENT = 8'd7;

    typedef enum logic [1:0] {
        FADE_OFF = 2'd0,
        FADE_LIN = 2'd1,
        FADE_LOG = 2'd2,
        FADE_EXP = 2'd3
    } fade_kind_t;

    // configuration register file
    typedef struct packed {
        logic [GAIN_W-1:0]  master_gain;
        logic [GAIN_W-1:0]  left_gain;
        logic [GAIN_W-1:0]  right_gain;
        logic               stereo_mode;
        fade_kind_t         fade_kind;
        logic [RUN_W-1:0]   run_length;
        logic [RUN_W-1:0]   fade_length;
        logic [PHASE_W-1:0] fade_increment;
    } cfg_t;

    // one classified sample on its way from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] source_sample;
        logic signed [SAMPLE_W-1:0] dest_left;
        logic signed [SAMPLE_W-1:0] dest_right;
        logic                       run_end;
        logic                       curve_on;
        logic [PHASE_W-1:0]         phase;
    } q_entry_t;

    typedef logic [15:0] curve_table_t [CURVE_ENTRIES];

    localparam logic [63:0] UNITY_Q30  = 64'd1073741824;
    localparam logic [63:0] INV_E_Q30  = 64'd395007542;
    localparam logic [63:0] SPAN64     = 64'(CURVE_SPAN);

    // bit-serial unsigned divide, only evaluated while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // q30 to q1.15, round half up, clamp to [0, 1.0]
    function automatic logic [15:0] q30_to_q15(input longint v);
        logic [63:0] r;
        longint      c;
        c = (v < 0) ? 64'sd0 : v;
        r = (64'(c) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[15:0];
    endfunction

    // exp(-x), x in q30, series on the fraction then powers of 1/e
    function automatic longint exp_neg_q30(input logic [63:0] x);
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        n    = x >> 30;
        f    = x & (UNITY_Q30 - 64'd1);
        term = UNITY_Q30;
        sum  = longint'(UNITY_Q30);
        for (int i = 1; i <= 14; i++) begin
            term = udiv64(term * f, 64'(i) << 30);
            if ((i & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = 64'(sum);
        for (int j = 0; j < 16; j++) begin
            if (64'(j) < n) begin
                v = (v * INV_E_Q30) >> 30;
            end
        end
        return longint'(v);
    endfunction

    // ln(y), y in q30, atanh series
    function automatic longint ln_q30(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        if (y <= UNITY_Q30) begin
            return 0;
        end
        z    = udiv64((y - UNITY_Q30) << 30, y + UNITY_Q30);
        z2   = (z * z) >> 30;
        term = z;
        sum  = '0;
        for (int i = 0; i < 15; i++) begin
            sum  = sum + udiv64(term, 64'(2 * i + 1));
            term = (term * z2) >> 30;
        end
        return longint'(sum << 1);
    endfunction

    // linear, logarithmic and exponential curves, one after another
    function automatic curve_table_t build_curve_table();
        curve_table_t tbl;
        logic [63:0]  kk;
        logic [63:0]  y;
        logic [63:0]  x;
        logic [63:0]  lin;
        for (int k = 0; k < CURVE_POINTS; k++) begin
            kk  = 64'(k);
            lin = udiv64(((SPAN64 - kk) * 64'd65536) + SPAN64, 64'd2 * SPAN64);
            tbl[k] = lin[15:0];
            y = udiv64((64'd2718 * SPAN64 - 64'd1718 * kk) << 30, 64'd1000 * SPAN64);
            tbl[CURVE_POINTS + k] = q30_to_q15(ln_q30(y));
            x = udiv64((64'd10 * kk) << 30, SPAN64);
            tbl[2 * CURVE_POINTS + k] = q30_to_q15(exp_neg_q30(x));
        end
        return tbl;
    endfunction

    localparam curve_table_t CURVE_TABLE = build_curve_table();

endpackage

// ===== hdl/amwf_front.sv =====
// front end: accepts input samples, tracks the run position and fade phase
// depends on amwf_pkg
module amwf_front #(
    parameter int POSITION_BITS = amwf_pkg::POSITION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  amwf_pkg::cfg_t                    cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [amwf_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              q_full,
    output logic                              q_push,
    output amwf_pkg::q_entry_t                q_data
);
    import amwf_pkg::*;

    localparam int CMP_W = ((POSITION_BITS > RUN_W) ? POSITION_BITS : RUN_W) + 1;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [RUN_W-1:0]         run_len;
    logic [CMP_W-1:0]         pos_ext;
    logic                     last;
    logic                     fading;
    logic [PHASE_W:0]         ph_sum;
    logic [PHASE_W-1:0]       ph_new;
    logic                     accept;

    // classify the sample against the run and advance the phase
    always_comb begin
        run_len = (cfg.run_length == '0) ? RUN_W'(1) : cfg.run_length;
        pos_ext = CMP_W'(pos_reg);
        last    = (pos_ext + CMP_W'(1)) >= CMP_W'(run_len);
        fading  = (cfg.fade_length != '0) &&
                  ((pos_ext + CMP_W'(cfg.fade_length)) >= CMP_W'(run_len));
        ph_sum  = {1'b0, phase_reg} + {1'b0, cfg.fade_increment};
        ph_new  = (ph_sum > {1'b0, UNITY_Q20}) ? UNITY_Q20 : ph_sum[PHASE_W-1:0];
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    // queue entry
    always_comb begin
        q_data.source_sample = $signed(s_tdata[15:0]);
        q_data.dest_left     = $signed(s_tdata[31:16]);
        q_data.dest_right    = $signed(s_tdata[47:32]);
        q_data.run_end       = last;
        q_data.curve_on      = fading && (cfg.fade_kind != FADE_OFF);
        q_data.phase         = ph_new;
    end

    // position and phase update per transaction
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        if (accept) begin
            if (last) begin
                pos_next   = '0;
                phase_next = '0;
            end else begin
                pos_next = pos_reg + POSITION_BITS'(1);
                if (fading) begin
                    phase_next = ph_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== hdl/amwf_queue.sv =====
// small fifo between the front end and the arithmetic back end
// depends on amwf_pkg
module amwf_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  amwf_pkg::q_entry_t   push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output amwf_pkg::q_entry_t   head
);
    import amwf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/amwf_back.sv =====
// back end: curve lookup and interpolation, gain scaling, mix and saturation
// depends on amwf_pkg (curve table, queue entry, config)
module amwf_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  amwf_pkg::cfg_t                    cfg,
    input  logic                              q_not_empty,
    output logic                              q_pop,
    input  amwf_pkg::q_entry_t                q_head,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [amwf_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import amwf_pkg::*;

    localparam int T_W    = PHASE_W + CURVE_IDX_W;
    localparam int GL_W   = GAIN_W * 2 + 1;
    localparam int GR_W   = GAIN_W * 2;
    localparam int SF_W   = SAMPLE_W + 1;
    localparam int S8_W   = 29;
    localparam int IP_W   = 39;
    localparam int SC_W   = 35;
    localparam int GP_W   = 52;
    localparam int ACC_W  = 48;

    localparam logic signed [IP_W-1:0]  INTERP_RND = 39'sd524288;
    localparam logic signed [SC_W-1:0]  SCALE_BIAS = 35'sd32767;
    localparam logic signed [GP_W-1:0]  BIAS_Q20   = 52'sd1048575;
    localparam logic signed [GP_W-1:0]  BIAS_Q21   = 52'sd2097151;
    localparam logic signed [ACC_W-1:0] MIX_BIAS   = 48'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_HI     = 48'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_LO     = -48'sd32768;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_INTERP = 5'b00010,
        ST_SCALE  = 5'b00100,
        ST_GAIN   = 5'b01000,
        ST_MIX    = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    // per-sample working registers
    logic signed [SAMPLE_W-1:0] src_reg, dl_reg, dr_reg;
    logic                       last_reg, curve_on_reg, clamp_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [15:0]                a_reg, b_reg;
    logic [GL_W-1:0]            gl_reg;
    logic [GR_W-1:0]            gr_reg;
    logic [16:0]                g_reg;
    logic signed [SF_W-1:0]     sf_reg;
    logic signed [S8_W-1:0]     s8l_reg, s8r_reg;

    // output register
    logic                       m_valid_reg;
    logic [OUT_DATA_W-1:0]      m_data_reg;
    logic                       m_last_reg;

    // lookup address from the queue head
    logic [T_W-1:0]             t_pos;
    logic [CURVE_IDX_W-1:0]     idx;
    logic [FRAC_W-1:0]          frac;
    logic                       clamp;
    logic [CURVE_ADDR_W-1:0]    base, addr_a, addr_b;
    logic [GAIN_W:0]            gsum;

    // datapath temporaries
    logic signed [16:0]         diff;
    logic signed [IP_W-1:0]     ip_prod, ip_sum;
    logic signed [SC_W-1:0]     sc_prod, sc_adj;
    logic signed [GP_W-1:0]     gpl, gpr, gpl_adj, gpr_adj, gpl_sh, gpr_sh;
    logic                       out_free;
    logic                       load, out_write;
    logic [SAMPLE_W-1:0]        mix_l, mix_r;

    // d + s - d*s/32768 in q8, truncated toward zero, saturated
    function automatic logic [SAMPLE_W-1:0] mix_sat(
        input logic signed [SAMPLE_W-1:0] d,
        input logic signed [S8_W-1:0]     s8
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] r;
        logic [SAMPLE_W-1:0]     res;
        acc = (ACC_W'(d) <<< 23) + (ACC_W'(s8) <<< 15) - ACC_W'(d) * ACC_W'(s8);
        if (acc < 0) begin
            acc = acc + MIX_BIAS;
        end
        r = acc >>> 23;
        if (r > SAT_HI) begin
            res = 16'h7FFF;
        end else if (r < SAT_LO) begin
            res = 16'h8000;
        end else begin
            res = r[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    // table position from the phase
    always_comb begin
        t_pos = T_W'(q_head.phase) * T_W'(CURVE_SPAN);
        idx   = t_pos[FRAC_W +: CURVE_IDX_W];
        frac  = t_pos[FRAC_W-1:0];
        clamp = (idx >= CURVE_IDX_W'(CURVE_SPAN));
        unique case (cfg.fade_kind)
            FADE_LIN:    base = '0;
            FADE_LOG:    base = CURVE_ADDR_W'(CURVE_POINTS);
            FADE_EXP:    base = CURVE_ADDR_W'(2 * CURVE_POINTS);
            default:     base = '0;
        endcase
        addr_a = base + (clamp ? CURVE_ADDR_W'(CURVE_SPAN) : CURVE_ADDR_W'(idx));
        addr_b = clamp ? addr_a : (base + CURVE_ADDR_W'(idx) + CURVE_ADDR_W'(1));
        gsum   = cfg.stereo_mode ? {1'b0, cfg.left_gain}
                                 : ({1'b0, cfg.left_gain} + {1'b0, cfg.right_gain});
    end

    // interpolation: a + round((b - a) * f / 2^20)
    always_comb begin
        diff    = $signed({1'b0, b_reg}) - $signed({1'b0, a_reg});
        ip_prod = IP_W'(diff) * $signed({{(IP_W - FRAC_W){1'b0}}, frac_reg});
        ip_sum  = $signed({{(IP_W - 16){1'b0}}, a_reg}) + ((ip_prod + INTERP_RND) >>> FRAC_W);
    end

    // fade scaling, truncated toward zero
    always_comb begin
        sc_prod = SC_W'(src_reg) * $signed({{(SC_W - 17){1'b0}}, g_reg});
        sc_adj  = (sc_prod < 0) ? (sc_prod + SCALE_BIAS) : sc_prod;
    end

    // gain scaling per lane, truncated toward zero
    always_comb begin
        gpl     = GP_W'(sf_reg) * $signed({{(GP_W - GL_W){1'b0}}, gl_reg});
        gpr     = GP_W'(sf_reg) * $signed({{(GP_W - GR_W){1'b0}}, gr_reg});
        gpl_adj = gpl;
        if (gpl < 0) begin
            gpl_adj = gpl + (cfg.stereo_mode ? BIAS_Q20 : BIAS_Q21);
        end
        gpr_adj = (gpr < 0) ? (gpr + BIAS_Q20) : gpr;
        gpl_sh  = cfg.stereo_mode ? (gpl_adj >>> 20) : (gpl_adj >>> 21);
        gpr_sh  = gpr_adj >>> 20;
    end

    // mix lanes
    always_comb begin
        mix_l = mix_sat(dl_reg, s8l_reg);
        mix_r = cfg.stereo_mode ? mix_sat(dr_reg, s8r_reg) : dr_reg;
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign load      = (state_reg == ST_IDLE) && q_not_empty;
    assign out_write = (state_reg == ST_MIX) && out_free;
    assign q_pop     = load;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_not_empty) state_next = ST_INTERP;
            ST_INTERP: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_MIX;
            ST_MIX:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers, one stage per sequencer step
    always_ff @(posedge aclk) begin
        if (load) begin
            src_reg      <= q_head.source_sample;
            dl_reg       <= q_head.dest_left;
            dr_reg       <= q_head.dest_right;
            last_reg     <= q_head.run_end;
            curve_on_reg <= q_head.curve_on;
            clamp_reg    <= clamp;
            frac_reg     <= frac;
            a_reg        <= CURVE_TABLE[addr_a];
            b_reg        <= CURVE_TABLE[addr_b];
            gl_reg       <= GL_W'(gsum) * GL_W'(cfg.master_gain);
            gr_reg       <= GR_W'(cfg.right_gain) * GR_W'(cfg.master_gain);
        end
        if (state_reg == ST_INTERP) begin
            if (!curve_on_reg) begin
                g_reg <= UNITY_Q15;
            end else if (clamp_reg) begin
                g_reg <= {1'b0, a_reg};
            end else begin
                g_reg <= ip_sum[16:0];
            end
        end
        if (state_reg == ST_SCALE) begin
            sf_reg <= sc_adj[15 +: SF_W];
        end
        if (state_reg == ST_GAIN) begin
            s8l_reg <= gpl_sh[S8_W-1:0];
            s8r_reg <= gpr_sh[S8_W-1:0];
        end
    end

    // output register, freed by the downstream transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_write) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_write) begin
            m_data_reg <= {mix_r, mix_l};
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hdl/audio_mix_with_fade_out.sv =====
// top level of the audio mixer with fade-out envelope: config registers,
// front end, queue and back end; depends on amwf_pkg and the amwf_* modules
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tdata: source_sample, dest_left, dest_right
//  m_       out  m_tvalid / m_tready  m_tdata: mixed_left, mixed_right; m_tlast: run_end
//  cfg_     in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// each sample walks the back end sequencer steps (load with table lookup,
// interpolate, fade scale, gain scale, mix) before the next is loaded; its
// chain of dependent multiplies sets the rate. the front end accepts into a
// 2-entry queue, so while m_tready is low up to 2 samples in the queue, one in
// the back end and one in the output register wait before s_tready drops.
// aresetn is synchronous; the curve table is constant, no clearing pass.
// cfg_ready is always high; writes are expected only while the block is idle.
module audio_mix_with_fade_out #(
    parameter int POSITION_BITS = amwf_pkg::POSITION_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] source_sample, [31:16] dest_left, [47:32] dest_right
    input  logic [amwf_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] mixed_left, [31:16] mixed_right
    output logic [amwf_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [amwf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [amwf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import amwf_pkg::*;

    cfg_t     cfg_reg;
    logic     q_push, q_full, q_pop, q_not_empty;
    q_entry_t q_in, q_head;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.master_gain    <= 16'd16384;
            cfg_reg.left_gain      <= 16'd16384;
            cfg_reg.right_gain     <= 16'd16384;
            cfg_reg.stereo_mode    <= 1'b0;
            cfg_reg.fade_kind      <= FADE_OFF;
            cfg_reg.run_length     <= 20'd1;
            cfg_reg.fade_length    <= '0;
            cfg_reg.fade_increment <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MASTER_GAIN:    cfg_reg.master_gain    <= cfg_data[GAIN_W-1:0];
                REG_LEFT_GAIN:      cfg_reg.left_gain      <= cfg_data[GAIN_W-1:0];
                REG_RIGHT_GAIN:     cfg_reg.right_gain     <= cfg_data[GAIN_W-1:0];
                REG_STEREO_MODE:    cfg_reg.stereo_mode    <= cfg_data[0];
                REG_FADE_KIND:      cfg_reg.fade_kind      <= fade_kind_t'(cfg_data[1:0]);
                REG_RUN_LENGTH:     cfg_reg.run_length     <= cfg_data[RUN_W-1:0];
                REG_FADE_LENGTH:    cfg_reg.fade_length    <= cfg_data[RUN_W-1:0];
                REG_FADE_INCREMENT: cfg_reg.fade_increment <= cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // input side: run position and fade phase
    amwf_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // decoupling queue
    amwf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // arithmetic and output register
    amwf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .q_head      (q_head),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
